// ----- src/lbcs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbcs_pkg: shared types and constants of the low-battery charge supervisor
// Status, shutdown-reason, LCD and register-index codes, reset values of the
// configuration registers and the slot schedule.
// ----------------------------------------------------------------------------
package lbcs_pkg;

  // Slot schedule
  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_EXIT   = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_VBUS_A = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_TEMP   = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] SLOT_VBUS_B = SLOT_W'(6);
  localparam logic [SLOT_W-1:0] SLOT_DISCH  = SLOT_W'(8);
  localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(SLOT_COUNT - 1);

  // Field widths
  localparam int VOLT_W = 13;
  localparam int CAP_W  = 7;
  localparam int TEMP_W = 8;
  localparam int CURR_W = 16;
  localparam int TICK_W = 12;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] HOT_LIMIT_RST   = 8'sd59;
  localparam logic signed [TEMP_W-1:0] COLD_LIMIT_RST  = -8'sd19;
  localparam logic [VOLT_W-1:0]        EXIT_VOLT_RST   = 13'd3450;
  localparam logic [CAP_W-1:0]         EXIT_CAP_RST    = 7'd3;
  localparam logic [VOLT_W-1:0]        SCREEN_VOLT_RST = 13'd3300;
  localparam logic [TICK_W-1:0]        TICK_LIMIT_RST  = 12'd3600;

  // Upper bound of the screen phase in the discharge test
  localparam int PHASE_HIGH = 15;

  typedef enum logic [1:0] {
    ST_RUNNING  = 2'd0,
    ST_EXIT     = 2'd1,
    ST_SHUTDOWN = 2'd2,
    ST_HALTED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_TEMP      = 3'd1,
    RSN_DISCHARGE = 3'd2,
    RSN_NO_VBUS   = 3'd3,
    RSN_TIMEOUT   = 3'd4
  } reason_t;

  typedef enum logic [1:0] {
    LCD_NONE = 2'd0,
    LCD_SHOW = 2'd1,
    LCD_OFF  = 2'd2
  } lcd_t;

  typedef enum logic [1:0] {
    PH_NEVER = 2'd0,
    PH_SHOWN = 2'd1,
    PH_OFF   = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOT_LIMIT   = 3'd0,
    REG_COLD_LIMIT  = 3'd1,
    REG_EXIT_VOLT   = 3'd2,
    REG_EXIT_CAP    = 3'd3,
    REG_SCREEN_VOLT = 3'd4,
    REG_TICK_LIMIT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                     button_level;
    logic                     vbus_present;
    logic signed [CURR_W-1:0] current_ma;
    logic signed [TEMP_W-1:0] temperature_c;
    logic [CAP_W-1:0]         capacity_pct;
    logic [VOLT_W-1:0]        voltage_mv;
  } in_item_t;

  typedef struct packed {
    logic    leds_unplugged;
    lcd_t    lcd_action;
    reason_t shutdown_reason;
    status_t status;
  } out_item_t;

endpackage

// ----- src/low_battery_charge_supervisor.sv -----
// ----------------------------------------------------------------------------
// low_battery_charge_supervisor: tick-driven low-battery charge supervisor
// Takes one battery sample per tick, runs the slot schedule and gives one
// status beat per tick.
// ----------------------------------------------------------------------------
// Use: each input beat on in_* is one tick carrying a battery sample. The
// tick counter selects one of ten slots (exit test and screen sequence,
// temperature window, discharge, VBUS, button redisplay); every tick gives
// exactly one result beat on out_* with status, shutdown reason, LCD action
// and the unplugged LED flag. After a charged exit or a shutdown every
// further tick reports status halted with all other fields zero.
// A beat accepted into the input register is evaluated combinationally and
// written to the output register, which drives out_tvalid. Throughput: one
// beat per cycle while out_tready does not stall, set by the single compare
// stage between input and output register. Stall: while out_tready is low
// the result is held; an empty input register still takes one more beat,
// then in_tready drops until the result drains. Reset (rst_n low,
// synchronous): counters, screen state and halt flag clear, limits return
// to their defaults, both channels empty. The user writes registers on cfg_*
// only while no tick is in flight (not enforced); cfg_ready is always high.
module low_battery_charge_supervisor (
  input  logic                              clk,
  input  logic                              rst_n,
  // voltage_mv[12:0] capacity_pct[19:13] temperature_c[27:20]
  // current_ma[43:28] vbus_present[44] button_level[45] zero[47:46]
  input  logic [lbcs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // status[1:0] shutdown_reason[4:2] lcd_action[6:5] leds_unplugged[7]
  output logic [lbcs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [lbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  localparam int SW = lbcs_pkg::SLOT_W;

  // Configuration registers
  logic signed [lbcs_pkg::TEMP_W-1:0] hot_limit_r;
  logic signed [lbcs_pkg::TEMP_W-1:0] cold_limit_r;
  logic [lbcs_pkg::VOLT_W-1:0]        exit_volt_r;
  logic [lbcs_pkg::CAP_W-1:0]         exit_cap_r;
  logic [lbcs_pkg::VOLT_W-1:0]        screen_volt_r;
  logic [lbcs_pkg::TICK_W-1:0]        tick_limit_r;

  // Supervisor state
  logic [lbcs_pkg::TICK_W-1:0]        tick_r, tick_nxt;
  logic [SW-1:0]                      slot_r, slot_nxt;
  lbcs_pkg::phase_t                   phase_r, phase_nxt;
  logic                               btn_on_r, btn_on_nxt;
  logic [lbcs_pkg::VOLT_W-1:0]        last_volt_r, last_volt_nxt;
  logic                               halted_r, halted_nxt;

  // Pipeline registers
  lbcs_pkg::in_item_t                 in_item_r;
  logic                               in_valid_r;
  lbcs_pkg::out_item_t                out_item_r, out_item_nxt;
  logic                               out_valid_r;
  logic                               advance;
  logic                               timeout;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_limit_r   <= lbcs_pkg::HOT_LIMIT_RST;
      cold_limit_r  <= lbcs_pkg::COLD_LIMIT_RST;
      exit_volt_r   <= lbcs_pkg::EXIT_VOLT_RST;
      exit_cap_r    <= lbcs_pkg::EXIT_CAP_RST;
      screen_volt_r <= lbcs_pkg::SCREEN_VOLT_RST;
      tick_limit_r  <= lbcs_pkg::TICK_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (lbcs_pkg::reg_idx_t'(cfg_index))
        lbcs_pkg::REG_HOT_LIMIT:   hot_limit_r   <= cfg_data[lbcs_pkg::TEMP_W-1:0];
        lbcs_pkg::REG_COLD_LIMIT:  cold_limit_r  <= cfg_data[lbcs_pkg::TEMP_W-1:0];
        lbcs_pkg::REG_EXIT_VOLT:   exit_volt_r   <= cfg_data[lbcs_pkg::VOLT_W-1:0];
        lbcs_pkg::REG_EXIT_CAP:    exit_cap_r    <= cfg_data[lbcs_pkg::CAP_W-1:0];
        lbcs_pkg::REG_SCREEN_VOLT: screen_volt_r <= cfg_data[lbcs_pkg::VOLT_W-1:0];
        lbcs_pkg::REG_TICK_LIMIT:  tick_limit_r  <= cfg_data[lbcs_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= lbcs_pkg::in_item_t'(in_tdata[$bits(lbcs_pkg::in_item_t)-1:0]);
    end
  end

  assign timeout = tick_r > tick_limit_r;

  // Evaluate the current slot
  always_comb begin
    out_item_nxt  = '0;
    phase_nxt     = phase_r;
    btn_on_nxt    = btn_on_r;
    last_volt_nxt = last_volt_r;
    halted_nxt    = halted_r;
    tick_nxt      = tick_r;
    slot_nxt      = slot_r;
    if (halted_r) begin
      out_item_nxt.status = lbcs_pkg::ST_HALTED;
    end else begin
      case (slot_r)
        lbcs_pkg::SLOT_EXIT: begin
          last_volt_nxt = in_item_r.voltage_mv;
          if (in_item_r.voltage_mv > exit_volt_r &&
              in_item_r.capacity_pct > exit_cap_r) begin
            out_item_nxt.status = lbcs_pkg::ST_EXIT;
          end else begin
            // step the screen sequence: shown goes off, never shown may show
            if (phase_r == lbcs_pkg::PH_SHOWN) begin
              phase_nxt               = lbcs_pkg::PH_OFF;
              out_item_nxt.lcd_action = lbcs_pkg::LCD_OFF;
            end
            if (in_item_r.voltage_mv > screen_volt_r && phase_r == lbcs_pkg::PH_NEVER) begin
              phase_nxt               = lbcs_pkg::PH_SHOWN;
              out_item_nxt.lcd_action = lbcs_pkg::LCD_SHOW;
            end
          end
        end
        lbcs_pkg::SLOT_TEMP: begin
          if (in_item_r.temperature_c > hot_limit_r ||
              in_item_r.temperature_c < cold_limit_r) begin
            out_item_nxt.status          = lbcs_pkg::ST_SHUTDOWN;
            out_item_nxt.shutdown_reason = lbcs_pkg::RSN_TEMP;
          end
        end
        lbcs_pkg::SLOT_DISCH: begin
          // upper phase bound can never be reached by a two-bit phase
          if (in_item_r.current_ma[lbcs_pkg::CURR_W-1] &&
              (phase_r == lbcs_pkg::PH_NEVER ||
               32'(phase_r) > lbcs_pkg::PHASE_HIGH)) begin
            out_item_nxt.status          = lbcs_pkg::ST_SHUTDOWN;
            out_item_nxt.shutdown_reason = lbcs_pkg::RSN_DISCHARGE;
          end
        end
        lbcs_pkg::SLOT_VBUS_A,
        lbcs_pkg::SLOT_VBUS_B: begin
          if (!in_item_r.vbus_present) begin
            out_item_nxt.status          = lbcs_pkg::ST_SHUTDOWN;
            out_item_nxt.shutdown_reason = lbcs_pkg::RSN_NO_VBUS;
          end
        end
        default: begin
          // button press redisplays the screen, release turns it off
          if (!in_item_r.button_level && last_volt_r > screen_volt_r &&
              phase_r == lbcs_pkg::PH_OFF && !btn_on_r) begin
            btn_on_nxt              = 1'b1;
            out_item_nxt.lcd_action = lbcs_pkg::LCD_SHOW;
          end
          if (in_item_r.button_level && btn_on_r) begin
            btn_on_nxt              = 1'b0;
            out_item_nxt.lcd_action = lbcs_pkg::LCD_OFF;
          end
        end
      endcase

      if (out_item_nxt.status != lbcs_pkg::ST_SHUTDOWN && timeout) begin
        out_item_nxt.status          = lbcs_pkg::ST_SHUTDOWN;
        out_item_nxt.shutdown_reason = lbcs_pkg::RSN_TIMEOUT;
      end

      out_item_nxt.leds_unplugged = (out_item_nxt.status == lbcs_pkg::ST_EXIT) &&
                                    !in_item_r.vbus_present;

      // advance the tick; the slot restarts after the last slot or when the counter wraps
      tick_nxt = tick_r + 1'b1;
      if (tick_nxt == '0 || slot_r == lbcs_pkg::SLOT_LAST) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
      halted_nxt = out_item_nxt.status != lbcs_pkg::ST_RUNNING;
    end
  end

  // Commit state and result when the beat moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      slot_r      <= '0;
      phase_r     <= lbcs_pkg::PH_NEVER;
      btn_on_r    <= 1'b0;
      last_volt_r <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        tick_r      <= tick_nxt;
        slot_r      <= slot_nxt;
        phase_r     <= phase_nxt;
        btn_on_r    <= btn_on_nxt;
        last_volt_r <= last_volt_nxt;
        halted_r    <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Once halted, the block stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  // Slot counter stays within the schedule
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < lbcs_pkg::SLOT_COUNT)
    else $error("slot counter out of range");

  // Each processed tick advances the counter by one
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r && !halted_r) |=> tick_r == $past(tick_r) + 1'b1)
    else $error("tick counter did not advance");

  // Unplugged LED flag only comes with a charged exit
  a_leds_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.leds_unplugged) |-> out_item_r.status == lbcs_pkg::ST_EXIT)
    else $error("LED flag without charged exit");

endmodule
